/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the meter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RPDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define RPDM_ASSERT_NEVER(lbl, cond, msg) `RPDM_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/core/rpdm_pkg.sv */
package rpdm_pkg;

  // Timer count width; equals the width of the timer_count field.
  localparam int unsigned CountWidth   = 16;
  localparam int unsigned TotalWidth   = 32;
  // Elapsed time is normalized until it fits this many bits.
  localparam int unsigned ElapsedBits  = 24;
  localparam int unsigned DutyWidth    = 8;
  localparam int unsigned CfgWidth     = 16;
  // Dividend width: on-time scaled by 255 plus the rounding half.
  localparam int unsigned RemWidth     = TotalWidth + DutyWidth;

  localparam logic [CfgWidth-1:0] WindowTicksReset = 16'd16;
  localparam logic [CfgWidth-1:0] TimerPeriodReset = 16'hD000;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_WRAP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_START = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RSVD  = 2'd3
  } direction_e;

  // Pin pair codes that carry on-time.
  localparam logic [1:0] PairRight = 2'd1;
  localparam logic [1:0] PairLeft  = 2'd2;

  typedef enum logic {
    REG_WINDOW_TICKS = 1'b0,
    REG_TIMER_PERIOD = 1'b1
  } reg_index_e;

  // One closed window, handed from the front to the back.
  typedef struct packed {
    logic [1:0]            direction;
    logic                  window_valid;
    logic [TotalWidth-1:0] on_time;
    logic [TotalWidth-1:0] now;
    logic [TotalWidth-1:0] begin_time;
  } job_t;

endpackage

/* rtl/core/rpdm_front.sv */
module rpdm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     opcode_i,
  input  logic [rpdm_pkg::CountWidth-1:0] timer_count_i,
  input  logic [1:0]                     pin_state_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_index_i,
  input  logic [rpdm_pkg::CfgWidth-1:0]  cfg_data_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output rpdm_pkg::job_t                 job_o
);

  logic [rpdm_pkg::CfgWidth-1:0]   window_ticks_q, timer_period_q;
  logic [rpdm_pkg::TotalWidth-1:0] time_base_q, time_base_d;
  logic [rpdm_pkg::CountWidth-1:0] last_ts_q, last_ts_d;
  logic [1:0]                      last_pair_q, last_pair_d;
  logic [rpdm_pkg::TotalWidth-1:0] right_q, right_d, left_q, left_d;
  logic [rpdm_pkg::TotalWidth-1:0] begin_q, begin_d;
  logic [rpdm_pkg::CfgWidth-1:0]   tick_q, tick_d;
  logic [1:0]                      held_q, held_d;

  logic                            accept;
  logic [rpdm_pkg::CountWidth-1:0] acct_to, span;
  logic [rpdm_pkg::TotalWidth-1:0] right_acc, left_acc, now;
  logic [rpdm_pkg::CfgWidth-1:0]   tick_inc;
  logic                            close, right_nz, left_nz, win_ok;
  logic [1:0]                      dir_new;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Account the open interval up to the event count, or to the period on a wrap.
  assign acct_to   = (opcode_i == rpdm_pkg::OP_WRAP) ? timer_period_q : timer_count_i;
  assign span      = acct_to - last_ts_q;
  assign right_acc = right_q + ((last_pair_q == rpdm_pkg::PairRight) ?
                     {{(rpdm_pkg::TotalWidth-rpdm_pkg::CountWidth){1'b0}}, span} : '0);
  assign left_acc  = left_q + ((last_pair_q == rpdm_pkg::PairLeft) ?
                     {{(rpdm_pkg::TotalWidth-rpdm_pkg::CountWidth){1'b0}}, span} : '0);
  assign now       = time_base_q +
                     {{(rpdm_pkg::TotalWidth-rpdm_pkg::CountWidth){1'b0}}, timer_count_i};

  assign tick_inc = tick_q + 1'b1;
  assign close    = (tick_inc >= window_ticks_q);
  assign right_nz = (right_acc != '0);
  assign left_nz  = (left_acc != '0);
  assign win_ok   = (now != begin_q) && (right_nz != left_nz);
  assign dir_new  = win_ok ? (right_nz ? rpdm_pkg::DIR_RIGHT : rpdm_pkg::DIR_LEFT) : held_q;

  always_comb begin
    time_base_d = time_base_q;
    last_ts_d   = last_ts_q;
    last_pair_d = last_pair_q;
    right_d     = right_q;
    left_d      = left_q;
    begin_d     = begin_q;
    tick_d      = tick_q;
    held_d      = held_q;
    push_o      = 1'b0;
    if (accept) begin
      unique case (opcode_i)
        rpdm_pkg::OP_EDGE: begin
          right_d     = right_acc;
          left_d      = left_acc;
          last_ts_d   = timer_count_i;
          last_pair_d = pin_state_i;
        end
        rpdm_pkg::OP_WRAP: begin
          right_d     = right_acc;
          left_d      = left_acc;
          last_ts_d   = '0;
          time_base_d = time_base_q +
                        {{(rpdm_pkg::TotalWidth-rpdm_pkg::CfgWidth){1'b0}}, timer_period_q};
        end
        rpdm_pkg::OP_TICK: begin
          if (close) begin
            tick_d    = '0;
            last_ts_d = timer_count_i;
            right_d   = '0;
            left_d    = '0;
            begin_d   = now;
            held_d    = dir_new;
            push_o    = 1'b1;
          end else begin
            tick_d = tick_inc;
          end
        end
        rpdm_pkg::OP_START: begin
          time_base_d = '0;
          last_ts_d   = timer_count_i;
          begin_d     = {{(rpdm_pkg::TotalWidth-rpdm_pkg::CountWidth){1'b0}}, timer_count_i};
          last_pair_d = pin_state_i;
          right_d     = '0;
          left_d      = '0;
          tick_d      = '0;
          held_d      = rpdm_pkg::DIR_NONE;
        end
        default: ;
      endcase
    end
  end

  // Exactly one side holds on-time when the window is valid, so OR gives the sum.
  assign job_o.direction    = dir_new;
  assign job_o.window_valid = win_ok;
  assign job_o.on_time      = right_acc | left_acc;
  assign job_o.now          = now;
  assign job_o.begin_time   = begin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ticks_q <= rpdm_pkg::WindowTicksReset;
      timer_period_q <= rpdm_pkg::TimerPeriodReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rpdm_pkg::REG_WINDOW_TICKS: window_ticks_q <= cfg_data_i;
        rpdm_pkg::REG_TIMER_PERIOD: timer_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_base_q <= '0;
      last_ts_q   <= '0;
      last_pair_q <= '0;
      right_q     <= '0;
      left_q      <= '0;
      begin_q     <= '0;
      tick_q      <= '0;
      held_q      <= rpdm_pkg::DIR_NONE;
    end else begin
      time_base_q <= time_base_d;
      last_ts_q   <= last_ts_d;
      last_pair_q <= last_pair_d;
      right_q     <= right_d;
      left_q      <= left_d;
      begin_q     <= begin_d;
      tick_q      <= tick_d;
      held_q      <= held_d;
    end
  end

endmodule

/* rtl/core/rpdm_queue.sv */
`include "assert_macros.svh"

module rpdm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rpdm_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rpdm_pkg::job_t job_o
);

  rpdm_pkg::job_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign job_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  `RPDM_ASSERT_NEVER(a_no_push_full, push_i && full_o, "push into full queue")
  `RPDM_ASSERT_NEVER(a_no_pop_empty, pop_i && empty_o, "pop from empty queue")

endmodule

/* rtl/core/rpdm_back.sv */
`include "assert_macros.svh"

module rpdm_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  rpdm_pkg::job_t                 job_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     direction_o,
  output logic [rpdm_pkg::DutyWidth-1:0] duty_o,
  output logic                           window_valid_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_NORM  = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic [rpdm_pkg::TotalWidth-1:0] elapsed_q, elapsed_d, on_q, on_d, div_q, div_d;
  logic [rpdm_pkg::RemWidth-1:0]   rem_q, rem_d, scaled;
  logic [rpdm_pkg::DutyWidth-1:0]  quot_q, quot_d;
  logic [3:0]                      step_q, step_d;
  logic [1:0]                      dir_q, dir_d;
  logic                            win_q, win_d;
  logic                            ge, load_out;

  logic                            out_valid_q;
  logic [1:0]                      out_dir_q;
  logic [rpdm_pkg::DutyWidth-1:0]  out_duty_q;
  logic                            out_win_q;

  // on*255 + elapsed/2, as (on << 8) - on plus the rounding half.
  assign scaled = ({on_q, {rpdm_pkg::DutyWidth{1'b0}}} - {{rpdm_pkg::DutyWidth{1'b0}}, on_q})
                + {{(rpdm_pkg::RemWidth-rpdm_pkg::TotalWidth+1){1'b0}},
                   elapsed_q[rpdm_pkg::TotalWidth-1:1]};
  assign ge       = (rem_q >= {{rpdm_pkg::DutyWidth{1'b0}}, div_q});
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    elapsed_d = elapsed_q;
    on_d      = on_q;
    div_d     = div_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    step_d    = step_q;
    dir_d     = dir_q;
    win_d     = win_q;
    pop_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o     = 1'b1;
          elapsed_d = job_i.now - job_i.begin_time;
          on_d      = job_i.on_time;
          dir_d     = job_i.direction;
          win_d     = job_i.window_valid;
          quot_d    = '0;
          state_d   = job_i.window_valid ? ST_NORM : ST_DONE;
        end
      end
      ST_NORM: begin
        // Halve both until elapsed fits the divider width.
        if (elapsed_q[rpdm_pkg::TotalWidth-1:rpdm_pkg::ElapsedBits] != '0) begin
          elapsed_d = elapsed_q >> 1;
          on_d      = on_q >> 1;
        end else begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        rem_d   = scaled;
        div_d   = {elapsed_q[rpdm_pkg::TotalWidth-rpdm_pkg::DutyWidth-1:0],
                   {rpdm_pkg::DutyWidth{1'b0}}};
        step_d  = 4'(rpdm_pkg::DutyWidth);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (step_q == 4'(rpdm_pkg::DutyWidth)) begin
          // Quotient at or above 256 saturates.
          if (ge) begin
            quot_d  = '1;
            state_d = ST_DONE;
          end else begin
            div_d  = div_q >> 1;
            step_d = step_q - 4'd1;
          end
        end else begin
          if (ge) begin
            rem_d = rem_q - {{rpdm_pkg::DutyWidth{1'b0}}, div_q};
          end
          quot_d = {quot_q[rpdm_pkg::DutyWidth-2:0], ge};
          div_d  = div_q >> 1;
          step_d = step_q - 4'd1;
          if (step_q == 4'd0) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    on_q      <= on_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    step_q    <= step_d;
    dir_q     <= dir_d;
    win_q     <= win_d;
  end

  // Output register: hold the result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_dir_q  <= dir_q;
      out_duty_q <= quot_q;
      out_win_q  <= win_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign direction_o    = out_dir_q;
  assign duty_o         = out_duty_q;
  assign window_valid_o = out_win_q;

  `RPDM_ASSERT(a_norm_fits, (state_q == ST_SCALE) |->
    (elapsed_q[rpdm_pkg::TotalWidth-1:rpdm_pkg::ElapsedBits] == '0),
    "elapsed not normalized before scaling")
  `RPDM_ASSERT(a_invalid_zero, (out_valid_q && !out_win_q) |-> (out_duty_q == '0),
    "invalid window with nonzero duty")

endmodule

/* rtl/core/rail_pwm_duty_direction_meter_top.sv */
// Channel   | Direction | Payload (low bit first)
// ----------+-----------+--------------------------------------------------------
// s_axis    | in        | tuser: opcode[1:0]; tdata: timer_count[15:0],
//           |           |   pin_state[17:16], zero[23:18]
// m_axis    | out       | tuser: window_valid[0]; tdata: direction[1:0],
//           |           |   duty[9:2], zero[15:10]
// cfg       | in        | cfg_index_i selects the register, cfg_data_i the value
//
// Edge, wrap, start and non-closing tick transfers are handled entirely in the front.
// A window close passes through the back: up to eight halving steps to bring elapsed
// under 24 bits, one scaling step, nine division steps (the first a saturation check).
// A two-entry queue sits between front and back; the front stalls only when it is full.
// The result sits in an output register; a stalled sink holds the back first and
// the front only once the queue has filled.
// Reset clears control state, loads register defaults; no clearing pass follows.
module rail_pwm_duty_direction_meter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // timer_count[15:0], pin_state[17:16], zero
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // direction[1:0], duty[9:2], zero
  output logic        m_axis_tuser,   // window_valid[0]
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  rpdm_pkg::job_t                 push_job, head_job;
  logic                           push, pop, q_full, q_empty;
  logic [1:0]                     direction;
  logic [rpdm_pkg::DutyWidth-1:0] duty;

  // Configuration is always taken; the front owns the registers.
  assign cfg_ready_o = 1'b1;

  // Front: accept and account every event, emit a job when a window closes.
  rpdm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .opcode_i      (s_axis_tuser),
    .timer_count_i (s_axis_tdata[15:0]),
    .pin_state_i   (s_axis_tdata[17:16]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Decouple event intake from the duty divider.
  rpdm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (head_job)
  );

  // Back: normalize, scale and divide, then present the result.
  rpdm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .job_i          (head_job),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .direction_o    (direction),
    .duty_o         (duty),
    .window_valid_o (m_axis_tuser)
  );

  assign m_axis_tdata = {6'b0, duty, direction};

endmodule

/* tb/rail_pwm_duty_direction_meter_top_tb.sv */
module rail_pwm_duty_direction_meter_top_tb;
  import rpdm_pkg::*;

  localparam logic [31:0] ElapsedMax     = 32'((64'd1 << ElapsedBits) - 1);
  localparam int unsigned DutyScale      = 255;
  // Covers the front plus the longest window close, with margin.
  localparam int unsigned SettleCycles   = 30;
  localparam int unsigned IdlePercent    = 18;
  localparam int unsigned SinkHoldCycles = 400;

  typedef struct packed {
    opcode_e               op;
    logic [CountWidth-1:0] count;
    logic [1:0]            pins;
  } pin_event_t;

  typedef struct packed {
    logic [1:0]           direction;
    logic [DutyWidth-1:0] duty;
    logic                 window_valid;
  } window_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i   = 1'b0;
  logic [15:0] cfg_data_i    = '0;

  rail_pwm_duty_direction_meter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Meter mirror: registers and measurement state as the block should hold them.
  logic [CfgWidth-1:0]   cfg_window_ticks = WindowTicksReset;
  logic [CfgWidth-1:0]   cfg_timer_period = TimerPeriodReset;
  logic [TotalWidth-1:0] time_base, right_on, left_on, window_start;
  logic [CountWidth-1:0] last_stamp, tick_count;
  logic [1:0]            pin_pair;
  direction_e            polarity;

  initial begin
    time_base    = '0;
    right_on     = '0;
    left_on      = '0;
    window_start = '0;
    last_stamp   = '0;
    tick_count   = '0;
    pin_pair     = '0;
    polarity     = DIR_NONE;
  end

  pin_event_t     event_feed_q[$];     // events waiting for the driver
  window_result_t window_results_q[$]; // predicted window closes, oldest first

  int items_offered   = 0;
  int items_accepted  = 0;
  int windows_seen    = 0;
  int windows_valid   = 0;
  int mismatches      = 0;
  int events_built    = 0;
  int hold_requests   = 0;
  int hold_served     = 0;
  int hold_left       = 0;
  bit steady_flow     = 1'b0;
  int gen_pos;

  // Credit the open interval to whichever single pin was high, then advance the stamp.
  function automatic void credit_span(input logic [CountWidth-1:0] upto);
    logic [CountWidth-1:0] span;
    span = upto - last_stamp;
    if (pin_pair == PairRight) right_on += span;
    else if (pin_pair == PairLeft) left_on += span;
    last_stamp = upto;
  endfunction

  // Apply one event to the mirror; returns 1 when the event closes a window.
  function automatic bit meter_predict(input pin_event_t ev, output window_result_t res);
    logic [TotalWidth-1:0] now, elapsed, right, left, on;
    logic [63:0]           quot;
    res = '0;
    case (ev.op)
      OP_EDGE: begin
        credit_span(ev.count);
        pin_pair = ev.pins;
        return 1'b0;
      end
      OP_WRAP: begin
        credit_span(cfg_timer_period);
        last_stamp = '0;
        time_base += cfg_timer_period;
        return 1'b0;
      end
      OP_START: begin
        time_base    = '0;
        last_stamp   = ev.count;
        window_start = ev.count;
        pin_pair     = ev.pins;
        right_on     = '0;
        left_on      = '0;
        tick_count   = '0;
        polarity     = DIR_NONE;
        return 1'b0;
      end
      default: ;
    endcase
    tick_count = tick_count + 1'b1;
    if (tick_count < cfg_window_ticks) return 1'b0;
    tick_count = '0;
    credit_span(ev.count);
    now          = time_base + last_stamp;
    right        = right_on;
    left         = left_on;
    elapsed      = now - window_start;
    right_on     = '0;
    left_on      = '0;
    window_start = now;
    if (elapsed != 0 && ((right != 0) != (left != 0))) begin
      polarity = (right != 0) ? DIR_RIGHT : DIR_LEFT;
      on = right + left;
      // Normalize so elapsed fits the divider width.
      while (elapsed > ElapsedMax) begin
        elapsed >>= 1;
        on >>= 1;
      end
      quot = (64'(on) * DutyScale + 64'(elapsed >> 1)) / 64'(elapsed);
      res.duty = (quot > 64'd255) ? 8'hFF : quot[7:0];
      res.window_valid = 1'b1;
    end
    res.direction = polarity;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      mismatches++;
    end
  endfunction

  // Driver: advance to the next event once the current transfer is done; hold otherwise.
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && items_accepted != items_offered)) begin
      if (event_feed_q.size() != 0 &&
          (steady_flow || $urandom_range(99) >= IdlePercent)) begin
        pin_event_t ev;
        ev = event_feed_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, ev.pins, ev.count};
        s_axis_tuser  <= ev.op;
        items_offered++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink: random backpressure, plus a long hold-off whenever one is requested.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = SinkHoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady_flow || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Monitor: predict on each accepted event, check each result transfer.
  always @(posedge clk_i) begin
    pin_event_t     ev;
    window_result_t predicted, observed;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        ev.op    = opcode_e'(s_axis_tuser);
        ev.count = s_axis_tdata[15:0];
        ev.pins  = s_axis_tdata[17:16];
        items_accepted++;
        if (meter_predict(ev, predicted)) window_results_q.push_back(predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        observed.direction    = m_axis_tdata[1:0];
        observed.duty         = m_axis_tdata[9:2];
        observed.window_valid = m_axis_tuser;
        windows_seen++;
        if (window_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual dir %0d duty %0d valid %0d",
                   $time, observed.direction, observed.duty, observed.window_valid);
          mismatches++;
        end else begin
          predicted = window_results_q.pop_front();
          if (observed.window_valid) windows_valid++;
          check_field("direction", predicted.direction, observed.direction);
          check_field("duty", predicted.duty, observed.duty);
          check_field("window_valid", predicted.window_valid, observed.window_valid);
        end
      end
    end
  end

  // Write one register; only called while the meter is idle.
  task automatic write_reg(input reg_index_e idx, input logic [CfgWidth-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_WINDOW_TICKS) cfg_window_ticks = value;
    else cfg_timer_period = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_event(input opcode_e op, input int count, input logic [1:0] pins);
    pin_event_t ev;
    ev.op    = op;
    ev.count = count[CountWidth-1:0];
    ev.pins  = pins;
    event_feed_q.push_back(ev);
    events_built++;
  endtask

  // Move the generator's timer forward, emitting a wrap each time it passes the period.
  task automatic advance_timer(input int period, input int max_step);
    gen_pos += $urandom_range(max_step, 1);
    while (gen_pos >= period) begin
      gen_pos -= period;
      push_event(OP_WRAP, $urandom_range(65535), 2'($urandom_range(3)));
    end
  endtask

  // One well-formed measurement: edges on a single rail (sometimes both), then ticks.
  task automatic gen_window_burst(input int period, input int ticks);
    int         step_max;
    bit         mixed;
    logic [1:0] side, pins;
    step_max = (period < 3000 || $urandom_range(9) == 0) ? 2 * period : 3000;
    mixed    = ($urandom_range(9) == 0);
    side     = 2'($urandom_range(2, 1));
    if ($urandom_range(4) == 0) begin
      gen_pos = $urandom_range(period - 1);
      push_event(OP_START, gen_pos, $urandom_range(1) ? side : 2'd0);
    end
    repeat (ticks) begin
      repeat ($urandom_range(3)) begin
        advance_timer(period, step_max);
        pins = mixed ? 2'($urandom_range(3)) : ($urandom_range(1) ? side : 2'd0);
        push_event(OP_EDGE, gen_pos, pins);
      end
      advance_timer(period, step_max);
      push_event(OP_TICK, gen_pos, 2'($urandom_range(3)));
    end
  endtask

  // Configure, then queue a phase of mostly well-formed windows with some raw noise.
  task automatic run_phase(input logic [CfgWidth-1:0] wticks, input logic [CfgWidth-1:0] period,
                           input int count);
    int target, per, ticks;
    write_reg(REG_WINDOW_TICKS, wticks);
    write_reg(REG_TIMER_PERIOD, period);
    per     = int'(period);
    ticks   = (wticks == 0 || wticks > 4) ? 1 : int'(wticks);
    target  = events_built + count;
    gen_pos = $urandom_range(per - 1);
    push_event(OP_START, gen_pos, 2'($urandom_range(2, 1)));
    while (events_built < target) begin
      if ($urandom_range(99) < 15)
        push_event(opcode_e'($urandom_range(3)), $urandom_range(65535),
                   2'($urandom_range(3)));
      else
        gen_window_burst(per, ticks);
    end
  endtask

  // Hold until the feed is empty and every predicted result has been checked.
  task automatic drain_results();
    do @(posedge clk_i);
    while (event_feed_q.size() != 0 || s_axis_tvalid || window_results_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: one tick per window at the default period.
    write_reg(REG_WINDOW_TICKS, 16'd1);
    write_reg(REG_TIMER_PERIOD, TimerPeriodReset);
    push_event(OP_START, 100, PairRight);
    push_event(OP_EDGE, 300, 2'd0);
    push_event(OP_EDGE, 400, PairRight);
    push_event(OP_TICK, 500, 2'd0);         // right rail only, clean duty
    push_event(OP_EDGE, 600, PairLeft);
    push_event(OP_TICK, 700, 2'd0);         // both rails had time: invalid, polarity held
    push_event(OP_TICK, 700, 2'd0);         // zero elapsed
    push_event(OP_EDGE, 700, 2'd0);
    push_event(OP_TICK, 800, 2'd0);         // no rail had time
    push_event(OP_EDGE, 800, PairLeft);
    push_event(OP_WRAP, 0, 2'd0);
    push_event(OP_TICK, 100, 2'd0);         // left rail across a wrap
    push_event(OP_EDGE, 100, 2'd3);
    push_event(OP_TICK, 16'hFFFF, 2'd3);    // both pins high counts for neither
    push_event(OP_START, 1000, PairRight);
    push_event(OP_TICK, 500, 2'd0);         // elapsed goes negative: full normalizing shift
    push_event(OP_START, 0, PairRight);
    push_event(OP_EDGE, 60000, PairRight);
    push_event(OP_WRAP, 16'hFFFF, 2'd3);
    push_event(OP_TICK, 0, 2'd0);           // on-time beyond elapsed: duty saturates
    push_event(OP_START, 16'hFFFF, 2'd3);
    push_event(OP_EDGE, 0, PairRight);
    push_event(OP_TICK, 16'h8000, 2'd1);
    drain_results();

    // Zero tick count: every tick closes; longest period.
    run_phase(16'd0, 16'hFFFF, 60);
    drain_results();

    // Shortest period: a wrap on every step.
    run_phase(16'd2, 16'd1, 150);
    drain_results();

    // A long stretch with no idling on either side.
    steady_flow = 1'b1;
    run_phase(16'd1, 16'd1000, 250);
    drain_results();
    steady_flow = 1'b0;

    // Stall the sink while events keep coming, so the inner queue fills.
    hold_requests++;
    run_phase(16'd3, TimerPeriodReset, 250);
    drain_results();

    // Widest tick count: windows rarely close.
    run_phase(16'hFFFF, 16'd40000, 40);
    drain_results();

    run_phase(16'd1, 16'hFFFF, 450);
    drain_results();

    $display("Covered %0d events and %0d window closes (%0d with measured duty),",
             items_accepted, windows_seen, windows_valid);
    $display("over tick counts 0..65535 and timer periods 1..65535, with %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: generous bound on the whole run.
  initial begin
    #4800000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
